// File: rtl/lfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfb_pkg: shared types and constants for the line folder
// Buffer geometry, character codes, the command word passed from the
// classifier to the emitter, and the tab remainder table.
// ----------------------------------------------------------------------------
package lfb_pkg;

    localparam int BUF_DEPTH   = 64;
    localparam int TAB_WIDTH   = 8;
    localparam int QUEUE_DEPTH = 4;

    localparam int ADDR_W  = $clog2(BUF_DEPTH);
    localparam int PTR_W   = ADDR_W + 1;
    localparam int LEN_W   = $clog2(BUF_DEPTH + 1);
    localparam int COL_W   = $clog2(BUF_DEPTH + TAB_WIDTH + 1);
    localparam int REM_W   = $clog2(TAB_WIDTH + 1);
    localparam int QADDR_W = $clog2(QUEUE_DEPTH);
    localparam int QPTR_W  = QADDR_W + 1;
    localparam int FW_W    = 6;

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_BLANK = 8'd32;

    localparam int          FOLD_WIDTH_RST = 20;
    localparam logic        REG_FOLD_WIDTH = 1'b0;

    typedef logic [PTR_W-1:0] ptr_t;

    // one emit job: len buffered characters from start, then a newline
    typedef struct packed {
        ptr_t             start;
        logic [LEN_W-1:0] len;
    } cmd_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_CHAR,
        BK_NL
    } back_state_t;

    // column modulo tab width, worked out at elaboration
    typedef logic [REM_W-1:0] rem_tab_t [1 << COL_W];

    function automatic rem_tab_t build_tab_rem();
        rem_tab_t t;
        for (int i = 0; i < (1 << COL_W); i++) begin
            t[i] = REM_W'(i % TAB_WIDTH);
        end
        return t;
    endfunction

    localparam rem_tab_t TAB_REM = build_tab_rem();

endpackage

// File: rtl/line_fold_at_blanks.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_fold_at_blanks: text line folder
// Folds a byte stream at a programmable column, preferring the last blank.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (s_*): one character word per handshake. Output channel
//   (m_*): the folded text, one character word per handshake;
//   m_last_of_run marks the final word caused by one input character.
//   APB port: register 0 at byte address 0 is fold_width (6 bits, reset 20).
//   Write it only while the block is idle.
// Throughput
//   Input is taken at one word per cycle while the job queue (4 deep) and
//   the 64-entry segment memory have room. A character that does not fold
//   produces nothing. A fold or newline posts a job; the emitter takes it
//   from the queue when idle and sends each buffered character as a memory
//   read, then a show, and then the newline. The emitter never overlaps a
//   read with a show and finishes one job before it takes the next.
// Reset and stall
//   aresetn (synchronous, active low) empties the segment, the queue and
//   the emitter; memory contents are left as they are. If the receiver
//   stalls, the emitter holds its word, jobs pile up in the queue, and
//   s_ready drops once the queue or the segment memory is full.
// ----------------------------------------------------------------------------
module line_fold_at_blanks (
    input  logic        aclk,
    input  logic        aresetn,
    // input characters
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_char,
    // output characters
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic        m_last_of_run,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lfb_pkg::*;

    logic [FW_W-1:0] fold_width_reg;
    logic            reg_hit;

    cmd_t    cmd_data, q_head;
    mem_wr_t mem_wr;
    ptr_t    back_ptr;
    logic    cmd_push, q_full, q_pop, q_empty;

    // ---- configuration register ----
    // Word-aligned decode; address bits below the word are ignored.
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_FOLD_WIDTH);
    assign prdata  = reg_hit ? 32'(fold_width_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_width_reg <= FW_W'(FOLD_WIDTH_RST);
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            fold_width_reg <= pwdata[FW_W-1:0];
        end
    end

    // ---- front: classify each character, store all but newlines, post emit jobs ----
    lfb_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fold_width (fold_width_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_char  (s_in_char),
        .back_ptr   (back_ptr),
        .q_full     (q_full),
        .cmd_push   (cmd_push),
        .cmd_data   (cmd_data),
        .mem_wr     (mem_wr)
    );

    // ---- job queue: decouples the two halves ----
    lfb_cmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_data (cmd_data),
        .full      (q_full),
        .pop       (q_pop),
        .head_data (q_head),
        .empty     (q_empty)
    );

    // ---- back: replay jobs from segment memory onto the output ----
    // back_ptr tells the front how far the memory has been drained, so
    // entries cut from the segment are not overwritten before they are sent.
    lfb_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .mem_wr        (mem_wr),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .back_ptr      (back_ptr),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_last_of_run (m_last_of_run)
    );

endmodule

// File: rtl/lfb_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfb_cmd_queue: emit job queue
// Small FIFO of emit jobs between the classifier and the emitter.
// ----------------------------------------------------------------------------
module lfb_cmd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  lfb_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output lfb_pkg::cmd_t head_data,
    output logic          empty
);
    import lfb_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;

    assign empty     = (wr_ptr_reg == rd_ptr_reg);
    assign full      = (wr_ptr_reg[QADDR_W-1:0] == rd_ptr_reg[QADDR_W-1:0]) &&
                       (wr_ptr_reg[QADDR_W] != rd_ptr_reg[QADDR_W]);
    assign head_data = entry_reg[rd_ptr_reg[QADDR_W-1:0]];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push && !full) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop && !empty) begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            entry_reg[wr_ptr_reg[QADDR_W-1:0]] <= push_data;
        end
    end

endmodule

// File: rtl/lfb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfb_front: character classifier
// Tracks column, segment head/tail and the last blank; stores each
// character but a newline, and posts an emit job on a fold or a newline.
// ----------------------------------------------------------------------------
module lfb_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [lfb_pkg::FW_W-1:0]       fold_width,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_in_char,
    input  lfb_pkg::ptr_t                  back_ptr,
    input  logic                           q_full,
    output logic                           cmd_push,
    output lfb_pkg::cmd_t                  cmd_data,
    output lfb_pkg::mem_wr_t               mem_wr
);
    import lfb_pkg::*;

    ptr_t             head_reg, head_next;
    ptr_t             tail_reg, tail_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             lb_valid_reg, lb_valid_next;
    ptr_t             lb_ptr_reg, lb_ptr_next;

    logic             is_nl, is_tab, is_bl;
    logic [COL_W-1:0] w_eff, ncol;
    logic [LEN_W-1:0] seg_len;
    ptr_t             occ;
    logic             buf_full, fold, accept;

    assign is_nl  = (s_in_char == CH_NL);
    assign is_tab = (s_in_char == CH_TAB);
    assign is_bl  = is_tab || (s_in_char == CH_BLANK);

    // effective width: at least one past a tab stop, at most the buffer
    always_comb begin
        w_eff = COL_W'(fold_width);
        if (w_eff <= COL_W'(TAB_WIDTH)) begin
            w_eff = COL_W'(TAB_WIDTH + 1);
        end
        if (w_eff > COL_W'(BUF_DEPTH)) begin
            w_eff = COL_W'(BUF_DEPTH);
        end
    end

    assign ncol = is_tab ? (col_reg + COL_W'(TAB_WIDTH) - COL_W'(TAB_REM[col_reg]))
                         : (col_reg + COL_W'(1));
    assign fold = !is_nl && (ncol >= w_eff);

    assign seg_len  = LEN_W'(tail_reg - head_reg);
    assign occ      = tail_reg - back_ptr;
    assign buf_full = (occ == PTR_W'(BUF_DEPTH));
    assign s_ready  = !q_full && !buf_full;
    assign accept   = s_valid && s_ready;

    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        col_next      = col_reg;
        lb_valid_next = lb_valid_reg;
        lb_ptr_next   = lb_ptr_reg;
        cmd_push      = 1'b0;
        cmd_data      = '0;
        mem_wr        = '0;
        if (accept) begin
            if (is_nl) begin
                cmd_push       = 1'b1;
                cmd_data.start = head_reg;
                cmd_data.len   = seg_len;
                head_next      = tail_reg;
                col_next       = '0;
                lb_valid_next  = 1'b0;
            end else begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = tail_reg[ADDR_W-1:0];
                mem_wr.data = s_in_char;
                tail_next   = tail_reg + PTR_W'(1);
                if (fold) begin
                    cmd_push       = 1'b1;
                    cmd_data.start = head_reg;
                    lb_valid_next  = 1'b0;
                    if (seg_len == '0) begin
                        // lone character reaching the width goes out by itself
                        cmd_data.len = LEN_W'(1);
                        head_next    = tail_reg + PTR_W'(1);
                        col_next     = '0;
                    end else if (is_bl) begin
                        cmd_data.len  = seg_len;
                        head_next     = tail_reg;
                        col_next      = is_tab ? COL_W'(TAB_WIDTH) : COL_W'(1);
                        lb_valid_next = 1'b1;
                        lb_ptr_next   = tail_reg;
                    end else if (lb_valid_reg && (lb_ptr_reg != head_reg)) begin
                        // break after the last blank; the tail holds no blank
                        cmd_data.len = LEN_W'(lb_ptr_reg - head_reg + PTR_W'(1));
                        head_next    = lb_ptr_reg + PTR_W'(1);
                        col_next     = COL_W'(tail_reg - lb_ptr_reg);
                    end else begin
                        cmd_data.len = seg_len;
                        head_next    = tail_reg;
                        col_next     = COL_W'(1);
                    end
                end else begin
                    col_next = ncol;
                    if (is_bl) begin
                        lb_valid_next = 1'b1;
                        lb_ptr_next   = tail_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            col_reg      <= '0;
            lb_valid_reg <= 1'b0;
        end else begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            col_reg      <= col_next;
            lb_valid_reg <= lb_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lb_ptr_reg <= lb_ptr_next;
    end

endmodule

// File: rtl/lfb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfb_back: segment emitter
// Holds the segment memory; replays each emit job as buffered
// characters followed by a newline on the output channel.
// ----------------------------------------------------------------------------
module lfb_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  lfb_pkg::mem_wr_t mem_wr,
    input  logic             q_empty,
    input  lfb_pkg::cmd_t    q_head,
    output logic             q_pop,
    output lfb_pkg::ptr_t    back_ptr,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_char,
    output logic             m_last_of_run
);
    import lfb_pkg::*;

    logic [7:0]       mem [BUF_DEPTH];
    logic [7:0]       rd_data_reg;
    back_state_t      state_reg, state_next;
    ptr_t             rd_ptr_reg, rd_ptr_next;
    logic [LEN_W-1:0] remain_reg, remain_next;
    logic             rd_en;

    assign back_ptr = rd_ptr_reg;

    always_comb begin
        state_next    = state_reg;
        rd_ptr_next   = rd_ptr_reg;
        remain_next   = remain_reg;
        q_pop         = 1'b0;
        rd_en         = 1'b0;
        m_valid       = 1'b0;
        m_out_char    = rd_data_reg;
        m_last_of_run = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    q_pop       = 1'b1;
                    rd_ptr_next = q_head.start;
                    remain_next = q_head.len;
                    state_next  = (q_head.len == '0) ? BK_NL : BK_READ;
                end
            end
            BK_READ: begin
                rd_en      = 1'b1;
                state_next = BK_CHAR;
            end
            BK_CHAR: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    rd_ptr_next = rd_ptr_reg + PTR_W'(1);
                    remain_next = remain_reg - LEN_W'(1);
                    state_next  = (remain_reg == LEN_W'(1)) ? BK_NL : BK_READ;
                end
            end
            BK_NL: begin
                m_valid       = 1'b1;
                m_out_char    = CH_NL;
                m_last_of_run = 1'b1;
                if (m_ready) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= BK_IDLE;
            rd_ptr_reg <= '0;
            remain_reg <= '0;
        end else begin
            state_reg  <= state_next;
            rd_ptr_reg <= rd_ptr_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_wr.en) begin
            mem[mem_wr.addr] <= mem_wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_ptr_reg[ADDR_W-1:0]];
        end
    end

endmodule
